FILE: rtl/fds_pkg.sv
// Package for the Forth data stack ALU: operator codes, request/result types.
// No dependencies.
package fds_pkg;
  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_POP = 5'd1, OP_TOP = 5'd2, OP_DUP = 5'd3, OP_2DUP = 5'd4,
    OP_SWAP = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_MUL = 5'd8, OP_DIV = 5'd9,
    OP_DROP = 5'd10, OP_2DROP = 5'd11, OP_OVER = 5'd12, OP_2OVER = 5'd13,
    OP_ROT = 5'd14, OP_MOD = 5'd15, OP_DIVMOD = 5'd16, OP_2SWAP = 5'd17
  } op_e;

  typedef struct packed {
    logic [4:0]         req_type;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] result_value;
    logic [6:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic        is_mul;
    logic [31:0] a;
    logic [31:0] b;
  } alu_cmd_t;
endpackage

FILE: rtl/forth_data_stack_alu.sv
// Forth data stack ALU top level: sequencer, stack memory, shared ALU.
// Divide, MOD and /MOD use the shared divider, which produces one quotient bit per
// cycle. One request at a time: busy is high from accept through the strobe cycle,
// so the block cannot take a new request before the result strobe of the last one.
// Reset clears the entry count and sets the stack limit (limit_q) to 64; memory is not cleared.
module forth_data_stack_alu #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fds_pkg::req_t req_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [6:0]    cfg_data_i,
  output logic          done_o,
  output fds_pkg::rsp_t rsp_o
);
  import fds_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CAP, S_ALU, S_WRITE, S_TOPRD, S_TOPCAP, S_DONE
  } state_e;

  state_e      state_q;
  logic [CW-1:0] cnt_q, lim_eff;
  logic [6:0]  limit_q;
  logic [4:0]  op_q;
  logic [31:0] pv_q;
  logic [31:0] ent_q [4];
  logic [2:0]  idx_q;
  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_q;
  logic [AW-1:0] raddr;
  logic        ok_q;
  logic [31:0] res_q;
  logic [31:0] wv_q [4];
  logic [2:0]  wn_q;
  logic [CW-1:0] newcnt_q;
  logic        rd_en;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;
  logic        done_q;
  alu_cmd_t    alu_cmd;
  logic        alu_done;
  logic [31:0] quot, rem, prod;

  logic [2:0] need, grow;
  always_comb begin
    need = 3'd0; grow = 3'd0;
    case (op_e'(req_i.req_type))
      OP_PUSH:   grow = 3'd1;
      OP_POP, OP_TOP, OP_DROP: need = 3'd1;
      OP_DUP:    begin need = 3'd1; grow = 3'd1; end
      OP_2DUP:   begin need = 3'd2; grow = 3'd2; end
      OP_OVER:   begin need = 3'd2; grow = 3'd1; end
      OP_2OVER:  begin need = 3'd4; grow = 3'd2; end
      OP_ROT:    need = 3'd3;
      OP_2SWAP:  need = 3'd4;
      default:   need = 3'd2;
    endcase
  end

  assign lim_eff = ({25'd0, limit_q} > 32'(STACK_DEPTH)) ? CW'(STACK_DEPTH)
                                                       : CW'(limit_q);

  logic accept, legal;
  assign accept = start && !busy;
  assign legal = (req_i.req_type <= 5'(OP_2SWAP)) && (cnt_q >= CW'(need)) &&
                 (grow == 3'd0 || ({1'b0, cnt_q} + (CW+1)'(grow)) <= {1'b0, lim_eff});

  // entries read: number of top entries to fetch into ent_q[0]=top .. [3]
  logic [2:0] nread_q;

  always_comb begin
    raddr = AW'(cnt_q - CW'(1) - CW'(idx_q));
    if (state_q == S_TOPRD) raddr = AW'(newcnt_q - CW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  assign rd_en = (state_q == S_READ) || (state_q == S_TOPRD);
  assign we = (state_q == S_WRITE) && (idx_q < wn_q);
  assign wdata = wv_q[idx_q[1:0]];
  always_comb begin
    waddr = AW'(newcnt_q - CW'(1) - CW'(idx_q));
  end

  always_comb begin
    alu_cmd.start = (state_q == S_ALU) && (idx_q == 3'd0) &&
                    (op_q == 5'(OP_MUL) ||
                     ((op_q == 5'(OP_DIV) || op_q == 5'(OP_MOD) ||
                       op_q == 5'(OP_DIVMOD)) && ent_q[0] != 32'd0));
    alu_cmd.is_mul = (op_q == 5'(OP_MUL));
    alu_cmd.is_div = (op_q != 5'(OP_MUL));
    alu_cmd.a = ent_q[1];
    alu_cmd.b = ent_q[0];
  end

  fds_alu u_alu (
    .clk_i, .rst_ni, .cmd_i(alu_cmd), .done_o(alu_done),
    .quot_o(quot), .rem_o(rem), .prod_o(prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; limit_q <= 7'd64; done_q <= 1'b0;
      idx_q <= '0; nread_q <= '0; wn_q <= '0; newcnt_q <= '0; ok_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
      case (state_q)
        S_IDLE: if (accept) begin
          op_q <= req_i.req_type; pv_q <= req_i.push_value;
          idx_q <= '0; ok_q <= legal; newcnt_q <= cnt_q; wn_q <= '0;
          if (!legal) state_q <= S_TOPRD;
          else begin
            nread_q <= need;
            state_q <= (need == 3'd0) ? S_ALU : S_READ;
          end
        end
        S_READ: state_q <= S_CAP;
        S_CAP: begin
          ent_q[idx_q[1:0]] <= rd_q;
          if (idx_q + 3'd1 == nread_q) begin idx_q <= '0; state_q <= S_ALU; end
          else begin idx_q <= idx_q + 3'd1; state_q <= S_READ; end
        end
        S_ALU: begin
          idx_q <= 3'd1;
          state_q <= S_WRITE;
          case (op_e'(op_q))
            OP_PUSH: begin wv_q[0] <= pv_q; wn_q <= 3'd1; newcnt_q <= cnt_q + CW'(1); end
            OP_POP: begin res_q <= ent_q[0]; newcnt_q <= cnt_q - CW'(1); end
            OP_DUP: begin wv_q[0] <= ent_q[0]; wn_q <= 3'd1; newcnt_q <= cnt_q + CW'(1); end
            OP_2DUP: begin
              wv_q[0] <= ent_q[0]; wv_q[1] <= ent_q[1]; wn_q <= 3'd2;
              newcnt_q <= cnt_q + CW'(2);
            end
            OP_SWAP: begin wv_q[0] <= ent_q[1]; wv_q[1] <= ent_q[0]; wn_q <= 3'd2; end
            OP_ADD: begin wv_q[0] <= ent_q[1] + ent_q[0]; wn_q <= 3'd1;
              newcnt_q <= cnt_q - CW'(1); end
            OP_SUB: begin wv_q[0] <= ent_q[1] - ent_q[0]; wn_q <= 3'd1;
              newcnt_q <= cnt_q - CW'(1); end
            OP_DROP: newcnt_q <= cnt_q - CW'(1);
            OP_2DROP: newcnt_q <= cnt_q - CW'(2);
            OP_OVER: begin wv_q[0] <= ent_q[1]; wn_q <= 3'd1; newcnt_q <= cnt_q + CW'(1); end
            OP_2OVER: begin
              wv_q[0] <= ent_q[2]; wv_q[1] <= ent_q[3]; wn_q <= 3'd2;
              newcnt_q <= cnt_q + CW'(2);
            end
            OP_ROT: begin
              wv_q[0] <= ent_q[2]; wv_q[1] <= ent_q[0]; wv_q[2] <= ent_q[1]; wn_q <= 3'd3;
            end
            OP_2SWAP: begin
              wv_q[0] <= ent_q[2]; wv_q[1] <= ent_q[3]; wv_q[2] <= ent_q[0];
              wv_q[3] <= ent_q[1]; wn_q <= 3'd4;
            end
            OP_MUL, OP_DIV, OP_MOD, OP_DIVMOD: begin
              if (op_q != 5'(OP_MUL) && ent_q[0] == 32'd0) begin
                ok_q <= 1'b0; state_q <= S_TOPRD;
              end else if (idx_q == 3'd0 || !alu_done) begin
                idx_q <= 3'd1; state_q <= S_ALU;
              end else begin
                case (op_e'(op_q))
                  OP_MUL: begin wv_q[0] <= prod; wn_q <= 3'd1;
                    newcnt_q <= cnt_q - CW'(1); end
                  OP_DIV: begin wv_q[0] <= quot; wn_q <= 3'd1;
                    newcnt_q <= cnt_q - CW'(1); end
                  OP_MOD: begin wv_q[0] <= rem; wn_q <= 3'd1;
                    newcnt_q <= cnt_q - CW'(1); end
                  default: begin wv_q[0] <= quot; wv_q[1] <= rem; wn_q <= 3'd2; end
                endcase
              end
            end
            default: ;
          endcase
          if (state_q == S_ALU && !(op_q >= 5'(OP_MUL) && op_q <= 5'(OP_DIV)) &&
              op_q != 5'(OP_MOD) && op_q != 5'(OP_DIVMOD))
            idx_q <= '0;
          else if (alu_done) idx_q <= '0;
        end
        S_WRITE: begin
          if (idx_q + 3'd1 >= wn_q || wn_q == 3'd0) begin
            cnt_q <= newcnt_q; idx_q <= '0;
            state_q <= (op_q == 5'(OP_POP)) ? S_DONE : S_TOPRD;
          end else idx_q <= idx_q + 3'd1;
        end
        S_TOPRD: state_q <= S_TOPCAP;
        S_TOPCAP: begin
          res_q <= (newcnt_q == '0) ? 32'd0 : rd_q;
          state_q <= S_DONE;
        end
        S_DONE: begin done_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE) || done_q;
  assign cfg_ready_o = 1'b1;
  assign done_o = done_q;
  assign rsp_o.ok = ok_q;
  assign rsp_o.result_value = res_q;
  assign rsp_o.entry_count = 7'(cnt_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH)) else $error("count above depth");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> busy) else $error("ready while working");
endmodule

FILE: rtl/fds_alu.sv
// Shared multi-cycle arithmetic unit: multiply and signed divide/remainder.
// Depends on fds_pkg.
module fds_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fds_pkg::alu_cmd_t cmd_i,
  output logic              done_o,
  output logic [31:0]       quot_o,
  output logic [31:0]       rem_o,
  output logic [31:0]       prod_o
);
  import fds_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] q_q, q_d, r_q, r_d, d_q, d_d, p_q, p_d;
  logic        nneg_q, nneg_d, dneg_q, dneg_d;
  logic [32:0] trial;
  logic [31:0] rsh;

  always_comb begin
    busy_d = busy_q; done_d = 1'b0; cnt_d = cnt_q;
    q_d = q_q; r_d = r_q; d_d = d_q; p_d = p_q;
    nneg_d = nneg_q; dneg_d = dneg_q;
    rsh = {r_q[30:0], q_q[31]};
    trial = {1'b0, rsh} - {1'b0, d_q};
    if (cmd_i.start) begin
      if (cmd_i.is_mul) begin
        p_d = cmd_i.a * cmd_i.b;
        done_d = 1'b1;
      end else if (cmd_i.is_div) begin
        nneg_d = cmd_i.a[31];
        dneg_d = cmd_i.b[31];
        q_d = cmd_i.a[31] ? -cmd_i.a : cmd_i.a;
        d_d = cmd_i.b[31] ? -cmd_i.b : cmd_i.b;
        r_d = '0;
        cnt_d = 6'd32;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (cnt_q != 6'd0) begin
        if (!trial[32]) begin
          r_d = trial[31:0];
          q_d = {q_q[30:0], 1'b1};
        end else begin
          r_d = rsh;
          q_d = {q_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
      end else begin
        q_d = (nneg_q ^ dneg_q) ? -q_q : q_q;
        r_d = nneg_q ? -r_q : r_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d; p_q <= p_d;
    nneg_q <= nneg_d; dneg_q <= dneg_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;
  assign prod_o = p_q;
endmodule
